>>> sv/drti_pkg.sv
// Shared types and constants for the double round-to-integral block.
`default_nettype none
package drti_pkg;

  typedef logic [1:0] opcode_t;

  localparam opcode_t OP_SPLIT = 2'd0;
  localparam opcode_t OP_FLOOR = 2'd1;
  localparam opcode_t OP_CEIL  = 2'd2;

  localparam int MANT_W = 52;
  localparam int EXP_W  = 11;
  localparam int LZ_W   = 6;

  localparam logic [EXP_W-1:0] EXP_ALL_ONES = 11'h7FF;
  localparam logic [EXP_W-1:0] EXP_BIAS     = 11'd1023;
  localparam logic [EXP_W-1:0] EXP_INT_MIN  = 11'd1075;

  typedef struct packed {
    logic                  sign;
    logic [EXP_W-1:0]      efield;
    logic                  need_norm;
    logic                  use_inc;
    logic [MANT_W-1:0]     mlow;
    logic [63:0]           whole;
    logic [63:0]           whole_inc;
    logic [63:0]           frac_direct;
  } split_t;

endpackage
`default_nettype wire

>>> sv/drti_if.sv
// Valid/ready channel interfaces for operand and result beats.
`default_nettype none
interface drti_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [63:0] value_bits;
  modport source (output valid, opcode, value_bits, input ready);
  modport sink   (input valid, opcode, value_bits, output ready);
endinterface

interface drti_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] whole_bits;
  logic [63:0] fraction_bits;
  modport source (output valid, whole_bits, fraction_bits, input ready);
  modport sink   (input valid, whole_bits, fraction_bits, output ready);
endinterface
`default_nettype wire

>>> sv/drti_split.sv
// Special-case decode, truncation mask and unit-step whole part.
`default_nettype none
module drti_split
  import drti_pkg::*;
(
  input  opcode_t     op,
  input  logic [63:0] xb,
  output split_t      s1
);

  logic              sign;
  logic [EXP_W-1:0]  efield;
  logic [EXP_W-1:0]  fdiff;
  logic [LZ_W-1:0]   fbits;
  logic [63:0]       keep;
  logic [63:0]       whole_m;
  logic              step_dir;

  assign sign     = xb[63];
  assign efield   = xb[62:52];
  assign fdiff    = EXP_INT_MIN - efield;
  assign fbits    = fdiff[LZ_W-1:0];
  assign keep     = ~((64'd1 << fbits) - 64'd1);
  assign whole_m  = xb & keep;
  assign step_dir = ((op == OP_FLOOR) && sign) || ((op == OP_CEIL) && !sign);

  always_comb begin
    s1             = '0;
    s1.sign        = sign;
    s1.efield      = efield;
    if (efield == EXP_ALL_ONES) begin
      s1.whole       = xb;
      s1.frac_direct = (xb[51:0] != '0) ? xb : {sign, 63'd0};
    end else if (efield < EXP_BIAS) begin
      s1.whole       = {sign, 63'd0};
      s1.frac_direct = xb;
      s1.whole_inc   = {sign, EXP_BIAS, 52'd0};
      s1.use_inc     = step_dir && (xb[62:0] != '0);
    end else if (efield >= EXP_INT_MIN) begin
      s1.whole       = xb;
      s1.frac_direct = {sign, 63'd0};
    end else begin
      s1.whole       = whole_m;
      s1.mlow        = xb[51:0] & ~keep[51:0];
      s1.need_norm   = 1'b1;
      s1.use_inc     = step_dir && ((xb[51:0] & ~keep[51:0]) != '0);
      s1.whole_inc   = {sign, whole_m[62:0] + (63'd1 << fbits)};
    end
  end

endmodule
`default_nettype wire

>>> sv/drti_norm.sv
// Fraction normalization and final whole-part select.
`default_nettype none
module drti_norm
  import drti_pkg::*;
(
  input  split_t      s1,
  output logic [63:0] whole_bits,
  output logic [63:0] fraction_bits
);

  logic [LZ_W-1:0]   lz;
  logic              found;
  logic [MANT_W-1:0] sh;
  logic [EXP_W-1:0]  fexp;

  always_comb begin
    lz    = '0;
    found = 1'b0;
    for (int i = MANT_W - 1; i >= 0; i--) begin
      if (!found && s1.mlow[i]) begin
        lz    = LZ_W'(MANT_W - 1 - i);
        found = 1'b1;
      end
    end
  end

  assign sh   = s1.mlow << lz;
  assign fexp = s1.efield - 11'd1 - {5'd0, lz};

  always_comb begin
    if (!s1.need_norm) begin
      fraction_bits = s1.frac_direct;
    end else if (!found) begin
      fraction_bits = 64'd0;
    end else begin
      fraction_bits = {s1.sign, fexp, sh[50:0], 1'b0};
    end
    whole_bits = s1.use_inc ? s1.whole_inc : s1.whole;
  end

endmodule
`default_nettype wire

>>> sv/double_round_to_integral.sv
// Top level: two-register pipeline computing trunc/floor/ceil and fraction of a double.
//
//  channel | dir | payload                          | handshake
//  in_bus  | in  | opcode[1:0], value_bits[63:0]    | valid/ready
//  out_bus | out | whole_bits[63:0], fraction_bits  | valid/ready
//
// One beat per cycle sustained while the result side does not wait; an accepted beat passes
// through the input register and then the result register before the result is valid.
// Each register advances when empty or when the register after it advances,
// so the input stalls only while both registers hold beats and the result side waits.
// rst_n clears the valid bits synchronously; payload registers are not reset.
`default_nettype none
module double_round_to_integral
  import drti_pkg::*;
(
  input  wire          clk,
  input  wire          rst_n,
  drti_in_if.sink      in_bus,
  drti_out_if.source   out_bus
);

  logic        v0_r, out_valid_r;
  opcode_t     op0_r;
  logic [63:0] xb0_r;
  split_t      split_s;
  logic [63:0] whole_r, whole_nxt, frac_r, frac_nxt;
  logic        ready0, ready1;

  assign ready1 = !out_valid_r || out_bus.ready;
  assign ready0 = !v0_r || ready1;

  assign in_bus.ready          = ready0;
  assign out_bus.valid         = out_valid_r;
  assign out_bus.whole_bits    = whole_r;
  assign out_bus.fraction_bits = frac_r;

  drti_split u_split (
    .op (op0_r),
    .xb (xb0_r),
    .s1 (split_s)
  );

  drti_norm u_norm (
    .s1            (split_s),
    .whole_bits    (whole_nxt),
    .fraction_bits (frac_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ready0) v0_r <= in_bus.valid;
      if (ready1) out_valid_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready0 && in_bus.valid) begin
      op0_r <= in_bus.opcode;
      xb0_r <= in_bus.value_bits;
    end
    if (ready1 && v0_r) begin
      whole_r <= whole_nxt;
      frac_r  <= frac_nxt;
    end
  end

`ifndef SYNTHESIS
  a_in_to_s0: assert property (@(posedge clk) disable iff (!rst_n)
    (in_bus.valid && in_bus.ready) |=> v0_r)
    else $error("accepted beat not captured");
  a_s0_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v0_r && !ready1) |=> (v0_r && $stable(xb0_r) && $stable(op0_r)))
    else $error("input stage lost beat under stall");
  a_s0_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (v0_r && ready1) |=> out_valid_r)
    else $error("input beat not forwarded");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_bus.ready) |=>
      (out_valid_r && $stable(whole_r) && $stable(frac_r)))
    else $error("result beat changed under stall");
`endif

endmodule
`default_nettype wire
